@@ hdl/half_space_block_rasterizer_top_assert.svh @@
// Assertion macros shared by the rasterizer RTL.
// Each macro expects signals named aclk and aresetn in the including module.
`ifndef HALF_SPACE_BLOCK_RASTERIZER_TOP_ASSERT_SVH
`define HALF_SPACE_BLOCK_RASTERIZER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HSBR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HSBR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/hsbr_pkg.sv @@
// Shared types and constants of the half-space block rasterizer.
// No dependencies; every RTL module imports this package.
package hsbr_pkg;

    // Default block edge in pixels.
    localparam int BLOCK_SIZE_DEF = 8;

    // Field widths.
    localparam int COORD_W = 16;   // 12.4 vertex coordinate
    localparam int POS_W   = 13;   // pixel position
    localparam int DELTA_W = 17;   // vertex difference
    localparam int EDGE_W  = 40;   // edge function value
    localparam int MASK_W  = 64;   // coverage mask
    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 96;

    // Command codes.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // One command as held in the input register, with the box terms
    // that are prepared on the way in.
    typedef struct packed {
        logic                      cmd;
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by_coord;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic [POS_W-1:0]          qmin_x;   // offset box corner over block size
        logic [POS_W-1:0]          qmin_y;
        logic signed [POS_W-1:0]   max_col;  // exclusive upper bounds
        logic signed [POS_W-1:0]   max_row;
    } in_item_t;

    // One edge: its value at the current block origin and its deltas.
    typedef struct packed {
        logic signed [EDGE_W-1:0]  org;
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
    } half_plane_t;

    // One result word.
    typedef struct packed {
        logic                    block_valid;
        logic signed [POS_W-1:0] block_col;
        logic signed [POS_W-1:0] block_row;
        logic [MASK_W-1:0]       coverage;
        logic                    full_block;
        logic                    last_block;
    } result_t;

endpackage

@@ hdl/hsbr_in_stage.sv @@
// Input register of the rasterizer, with bounding-box preparation.
// Depends on hsbr_pkg.
module hsbr_in_stage #(
    parameter int BLOCK_SIZE = hsbr_pkg::BLOCK_SIZE_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [hsbr_pkg::S_TDATA_W-1:0]   s_tdata,   // ax, ay, bx, by_coord, cx, cy
    input  logic                             s_tuser,   // command
    input  logic                             advance,
    output logic                             item_valid,
    output hsbr_pkg::in_item_t               item
);
    import hsbr_pkg::*;

    // Box corner offset that keeps the division operand non-negative.
    localparam int BoxOffset = BLOCK_SIZE * ((2048 + BLOCK_SIZE - 1) / BLOCK_SIZE);
    localparam int U_W       = POS_W + 1;
    localparam int RECIP_SH  = 20;
    localparam int Recip     = (1 << RECIP_SH) / BLOCK_SIZE + 1;
    localparam int PROD_W    = U_W + RECIP_SH;

    logic signed [COORD_W-1:0] vx [3];
    logic signed [COORD_W-1:0] vy [3];
    logic signed [COORD_W-1:0] min_x, min_y, max_x, max_y;
    logic signed [COORD_W:0]   rnd_min_x, rnd_min_y, rnd_max_x, rnd_max_y;
    logic signed [POS_W-1:0]   ceil_min_x, ceil_min_y;
    logic [U_W-1:0]            u_x, u_y;
    logic [PROD_W-1:0]         prod_x, prod_y;
    logic                      in_valid_reg;
    in_item_t                  item_reg;
    in_item_t                  item_next;

    // Unpack the vertices, first field in the lowest bits.
    assign vx[0] = s_tdata[0*COORD_W +: COORD_W];
    assign vy[0] = s_tdata[1*COORD_W +: COORD_W];
    assign vx[1] = s_tdata[2*COORD_W +: COORD_W];
    assign vy[1] = s_tdata[3*COORD_W +: COORD_W];
    assign vx[2] = s_tdata[4*COORD_W +: COORD_W];
    assign vy[2] = s_tdata[5*COORD_W +: COORD_W];

    // Extremes of the three vertices.
    always_comb begin
        min_x = (vx[0] < vx[1]) ? vx[0] : vx[1];
        min_x = (min_x < vx[2]) ? min_x : vx[2];
        min_y = (vy[0] < vy[1]) ? vy[0] : vy[1];
        min_y = (min_y < vy[2]) ? min_y : vy[2];
        max_x = (vx[0] > vx[1]) ? vx[0] : vx[1];
        max_x = (max_x > vx[2]) ? max_x : vx[2];
        max_y = (vy[0] > vy[1]) ? vy[0] : vy[1];
        max_y = (max_y > vy[2]) ? max_y : vy[2];
    end

    // Round up to whole pixels: ceil(v / 16) is (v + 15) shifted right by four.
    assign rnd_min_x  = (COORD_W+1)'(min_x) + 17'sd15;
    assign rnd_min_y  = (COORD_W+1)'(min_y) + 17'sd15;
    assign rnd_max_x  = (COORD_W+1)'(max_x) + 17'sd15;
    assign rnd_max_y  = (COORD_W+1)'(max_y) + 17'sd15;
    assign ceil_min_x = rnd_min_x[COORD_W:4];
    assign ceil_min_y = rnd_min_y[COORD_W:4];

    // Divide the offset corner by the block size through a reciprocal multiply.
    // The reciprocal is rounded up; the error stays below one block step.
    assign u_x    = U_W'(ceil_min_x) + U_W'(BoxOffset);
    assign u_y    = U_W'(ceil_min_y) + U_W'(BoxOffset);
    assign prod_x = PROD_W'(u_x) * PROD_W'(Recip);
    assign prod_y = PROD_W'(u_y) * PROD_W'(Recip);

    always_comb begin
        item_next          = item_reg;
        item_next.cmd      = s_tuser;
        item_next.ax       = vx[0];
        item_next.ay       = vy[0];
        item_next.bx       = vx[1];
        item_next.by_coord = vy[1];
        item_next.cx       = vx[2];
        item_next.cy       = vy[2];
        item_next.qmin_x   = prod_x[RECIP_SH +: POS_W];
        item_next.qmin_y   = prod_y[RECIP_SH +: POS_W];
        item_next.max_col  = rnd_max_x[COORD_W:4];
        item_next.max_row  = rnd_max_y[COORD_W:4];
    end

    // The register takes a new word whenever it is empty or being emptied.
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= item_next;
        end
    end

    assign item_valid = in_valid_reg;
    assign item       = item_reg;

endmodule

@@ hdl/hsbr_coverage.sv @@
// Per-pixel inside test of one block against each edge of the triangle.
// Depends on hsbr_pkg.
module hsbr_coverage #(
    parameter int BLOCK_SIZE = hsbr_pkg::BLOCK_SIZE_DEF
) (
    input  hsbr_pkg::half_plane_t [2:0]      edges,
    output logic [hsbr_pkg::MASK_W-1:0]      mask,
    output logic                             full
);
    import hsbr_pkg::*;

    localparam int NPix        = BLOCK_SIZE * BLOCK_SIZE;
    localparam int CornerTr    = BLOCK_SIZE - 1;
    localparam int CornerBl    = (BLOCK_SIZE - 1) * BLOCK_SIZE;
    localparam int CornerBr    = NPix - 1;

    logic [NPix-1:0] hits;

    // Each pixel adds fixed multiples of the deltas to the origin value.
    for (genvar gi = 0; gi < BLOCK_SIZE; gi++) begin : g_row
        for (genvar gj = 0; gj < BLOCK_SIZE; gj++) begin : g_col
            localparam logic signed [EDGE_W-1:0] RowK = EDGE_W'(16 * gi);
            localparam logic signed [EDGE_W-1:0] ColK = EDGE_W'(16 * gj);
            logic signed [EDGE_W-1:0] val [3];
            for (genvar gk = 0; gk < 3; gk++) begin : g_edge
                assign val[gk] = edges[gk].org + EDGE_W'(edges[gk].dx) * RowK
                               - EDGE_W'(edges[gk].dy) * ColK;
            end
            assign hits[gi*BLOCK_SIZE + gj] = (val[0] > 0) && (val[1] > 0) && (val[2] > 0);
        end
    end

    assign mask = MASK_W'(hits);

    // The four corners are pixels of the mask.
    assign full = hits[0] && hits[CornerTr] && hits[CornerBl] && hits[CornerBr];

endmodule

@@ hdl/hsbr_core.sv @@
// Triangle setup and block walker: edge state, bounding box and block position.
// Depends on hsbr_pkg, hsbr_coverage and the assertion macro header.
`include "half_space_block_rasterizer_top_assert.svh"
module hsbr_core #(
    parameter int BLOCK_SIZE = hsbr_pkg::BLOCK_SIZE_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  hsbr_pkg::in_item_t    item,
    output hsbr_pkg::result_t     result
);
    import hsbr_pkg::*;

    localparam int BoxOffset = BLOCK_SIZE * ((2048 + BLOCK_SIZE - 1) / BLOCK_SIZE);
    localparam int SC_W      = POS_W + 2;
    localparam int OFS_W     = COORD_W + 2;
    localparam int PROD_W    = DELTA_W + OFS_W;
    localparam logic signed [EDGE_W-1:0] BlockStep = EDGE_W'(16 * BLOCK_SIZE);

    half_plane_t [2:0]          edge_reg, edge_next;
    logic signed [EDGE_W-1:0]   row_org_reg [3];
    logic signed [EDGE_W-1:0]   row_org_next [3];
    logic signed [POS_W-1:0]    box_min_col_reg, box_min_col_next;
    logic signed [POS_W-1:0]    box_max_col_reg, box_max_col_next;
    logic signed [POS_W-1:0]    box_max_row_reg, box_max_row_next;
    logic signed [POS_W-1:0]    cur_col_reg, cur_col_next;
    logic signed [POS_W-1:0]    cur_row_reg, cur_row_next;
    logic                       active_reg, active_next;

    logic signed [COORD_W-1:0]  vx [3];
    logic signed [COORD_W-1:0]  vy [3];
    logic [SC_W-1:0]            scaled_x, scaled_y;
    logic signed [POS_W-1:0]    ld_min_col, ld_min_row;
    logic                       ld_active;
    logic signed [DELTA_W-1:0]  ld_dx [3];
    logic signed [DELTA_W-1:0]  ld_dy [3];
    logic signed [EDGE_W-1:0]   ld_org [3];
    logic signed [EDGE_W-1:0]   col_step [3];
    logic signed [EDGE_W-1:0]   row_step [3];
    logic signed [POS_W:0]      step_col, step_row;
    logic [MASK_W-1:0]          cov_mask;
    logic                       cov_full;

    assign vx[0] = item.ax;
    assign vy[0] = item.ay;
    assign vx[1] = item.bx;
    assign vy[1] = item.by_coord;
    assign vx[2] = item.cx;
    assign vy[2] = item.cy;

    // Box corner: quotient times block size, minus the offset added on the way in.
    assign scaled_x   = SC_W'(item.qmin_x) * SC_W'(BLOCK_SIZE);
    assign scaled_y   = SC_W'(item.qmin_y) * SC_W'(BLOCK_SIZE);
    assign ld_min_col = POS_W'(scaled_x - SC_W'(BoxOffset));
    assign ld_min_row = POS_W'(scaled_y - SC_W'(BoxOffset));
    assign ld_active  = (ld_min_col < item.max_col) && (ld_min_row < item.max_row);

    // Edge setup: value at the box corner taken relative to the start vertex,
    // plus one for top and left edges.
    for (genvar gk = 0; gk < 3; gk++) begin : g_setup
        localparam int Nxt = (gk + 1) % 3;
        logic signed [OFS_W-1:0]  ofs_x, ofs_y;
        logic signed [PROD_W-1:0] prod_a, prod_b;
        logic                     top_left;

        assign ld_dx[gk] = DELTA_W'(vx[gk]) - DELTA_W'(vx[Nxt]);
        assign ld_dy[gk] = DELTA_W'(vy[gk]) - DELTA_W'(vy[Nxt]);
        assign ofs_x     = OFS_W'(vx[gk]) - (OFS_W'(ld_min_col) <<< 4);
        assign ofs_y     = OFS_W'(vy[gk]) - (OFS_W'(ld_min_row) <<< 4);
        assign prod_a    = PROD_W'(ld_dy[gk]) * PROD_W'(ofs_x);
        assign prod_b    = PROD_W'(ld_dx[gk]) * PROD_W'(ofs_y);
        assign top_left  = (ld_dy[gk] < 0) || ((ld_dy[gk] == 0) && (ld_dx[gk] > 0));
        assign ld_org[gk] = EDGE_W'(prod_a) - EDGE_W'(prod_b)
                          + EDGE_W'(signed'({1'b0, top_left}));

        // Moving one block right or one block down.
        assign col_step[gk] = EDGE_W'(edge_reg[gk].dy) * BlockStep;
        assign row_step[gk] = EDGE_W'(edge_reg[gk].dx) * BlockStep;
    end

    assign step_col = (POS_W+1)'(cur_col_reg) + (POS_W+1)'(BLOCK_SIZE);
    assign step_row = (POS_W+1)'(cur_row_reg) + (POS_W+1)'(BLOCK_SIZE);

    // Inside test of the current block.
    hsbr_coverage #(
        .BLOCK_SIZE (BLOCK_SIZE)
    ) u_coverage (
        .edges (edge_reg),
        .mask  (cov_mask),
        .full  (cov_full)
    );

    // Next state and result of the command in the input register.
    always_comb begin
        edge_next        = edge_reg;
        row_org_next     = row_org_reg;
        box_min_col_next = box_min_col_reg;
        box_max_col_next = box_max_col_reg;
        box_max_row_next = box_max_row_reg;
        cur_col_next     = cur_col_reg;
        cur_row_next     = cur_row_reg;
        active_next      = active_reg;
        result           = '0;

        if (item.cmd == CMD_LOAD) begin
            for (int k = 0; k < 3; k++) begin
                edge_next[k].org = ld_org[k];
                edge_next[k].dx  = ld_dx[k];
                edge_next[k].dy  = ld_dy[k];
                row_org_next[k]  = ld_org[k];
            end
            box_min_col_next  = ld_min_col;
            box_max_col_next  = item.max_col;
            box_max_row_next  = item.max_row;
            cur_col_next      = ld_min_col;
            cur_row_next      = ld_min_row;
            active_next       = ld_active;
            result.last_block = !ld_active;
        end else if (!active_reg) begin
            result.last_block = 1'b1;
        end else begin
            result.block_valid = 1'b1;
            result.block_col   = cur_col_reg;
            result.block_row   = cur_row_reg;
            result.coverage    = cov_mask;
            result.full_block  = cov_full;
            if (step_col >= (POS_W+1)'(box_max_col_reg)) begin
                // Wrap to the start of the next block row.
                cur_col_next = box_min_col_reg;
                cur_row_next = POS_W'(step_row);
                for (int k = 0; k < 3; k++) begin
                    edge_next[k].org = row_org_reg[k] + row_step[k];
                    row_org_next[k]  = row_org_reg[k] + row_step[k];
                end
                if (step_row >= (POS_W+1)'(box_max_row_reg)) begin
                    active_next = 1'b0;
                end
            end else begin
                cur_col_next = POS_W'(step_col);
                for (int k = 0; k < 3; k++) begin
                    edge_next[k].org = edge_reg[k].org - col_step[k];
                end
            end
            result.last_block = !active_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
        end else if (advance) begin
            active_reg <= active_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            edge_reg        <= edge_next;
            row_org_reg     <= row_org_next;
            box_min_col_reg <= box_min_col_next;
            box_max_col_reg <= box_max_col_next;
            box_max_row_reg <= box_max_row_next;
            cur_col_reg     <= cur_col_next;
            cur_row_reg     <= cur_row_next;
        end
    end

    // A visited block always lies inside the box.
    `HSBR_ASSERT_NOW(a_walk_in_box, advance && item.cmd == CMD_STEP && active_reg, cur_col_reg >= box_min_col_reg && cur_col_reg < box_max_col_reg && cur_row_reg < box_max_row_reg, "block walker left the bounding box")
    // A load puts the walker on the box corner.
    `HSBR_ASSERT_NEXT(a_load_origin, advance && item.cmd == CMD_LOAD, cur_col_reg == box_min_col_reg, "load did not start at the box corner")

endmodule

@@ hdl/half_space_block_rasterizer_top.sv @@
// Top level of the half-space block rasterizer: stream ports and result register.
// Depends on hsbr_pkg, hsbr_in_stage, hsbr_core and the assertion macro header.
//
// Usage: each word on the s_ channel is one command. s_tuser = 0 loads a
// triangle from the three vertices in s_tdata; s_tuser = 1 steps to the next
// block of the loaded triangle in row order. Every command gives exactly one
// word on the m_ channel. A load answers with m_tuser = 0 and m_tlast set when
// its bounding box is empty. A step answers with the block position and its
// coverage mask (m_tuser = 1), or with m_tuser = 0 and m_tlast = 1 when no
// block remains. m_tlast marks the last block of a triangle.
// An accepted command waits in the input register and moves on into the result
// register once that is free or being read. Throughput: one command per cycle,
// loads and steps alike, while the receiver does not stall; the load setup of six
// multiplies fits between the input register and the core's edge registers, the
// per-pixel edge adders between those and the result register.
// Reset clears both registers and leaves no triangle loaded, so a step then
// answers with m_tlast = 1. When the receiver stalls, the result register
// holds its word, the input register takes one more command, and then
// s_tready drops until m_tready returns.
`include "half_space_block_rasterizer_top_assert.svh"
module half_space_block_rasterizer_top #(
    parameter int BLOCK_SIZE = hsbr_pkg::BLOCK_SIZE_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [hsbr_pkg::S_TDATA_W-1:0]   s_tdata,   // ax, ay, bx, by_coord, cx, cy
    input  logic                             s_tuser,   // command
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [hsbr_pkg::M_TDATA_W-1:0]   m_tdata,   // block_col, block_row, coverage,
                                                        // full_block, zero fill
    output logic                             m_tuser,   // block_valid
    output logic                             m_tlast    // last_block
);
    import hsbr_pkg::*;

    localparam int PAD_W = M_TDATA_W - 2 * POS_W - MASK_W - 1;

    logic     item_valid;
    logic     advance;
    in_item_t item;
    result_t  result;
    result_t  out_reg;
    logic     out_valid_reg;

    // The command moves on when the result register is free or being read.
    assign advance = item_valid && (!out_valid_reg || m_tready);

    hsbr_in_stage #(
        .BLOCK_SIZE (BLOCK_SIZE)
    ) u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    hsbr_core #(
        .BLOCK_SIZE (BLOCK_SIZE)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item),
        .result  (result)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {PAD_W'(0), out_reg.full_block, out_reg.coverage,
                       out_reg.block_row, out_reg.block_col};
    assign m_tuser  = out_reg.block_valid;
    assign m_tlast  = out_reg.last_block;

    // A command leaving the input register always lands in the result register.
    `HSBR_ASSERT_NEXT(a_result_loaded, advance, m_tvalid, "result register missed a command")
    // Words that report no block carry no coverage.
    `HSBR_ASSERT_NOW(a_empty_no_cover, m_tvalid && !out_reg.block_valid, out_reg.coverage == '0 && !out_reg.full_block, "coverage on a word without a block")

endmodule

@@ test/half_space_block_rasterizer_top_tb.sv @@
// Self-checking testbench for the half-space block rasterizer top level.
// It predicts every result word from its own model of triangle setup and block walking.
// Depends on hsbr_pkg and half_space_block_rasterizer_top only.
module half_space_block_rasterizer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hsbr_pkg::*;

    localparam int BLOCK       = BLOCK_SIZE_DEF;
    localparam int CYCLE_LIMIT = 300000;
    localparam int PRINT_LIMIT = 50;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    // Predicted triangle setup and walk position.
    longint tri_const [3];
    int     tri_dx [3];
    int     tri_dy [3];
    int     box_col_lo;
    int     box_col_hi;
    int     box_row_hi;
    int     walk_col;
    int     walk_row;
    bit     tri_active;

    // Expected result words, oldest first.
    result_t pending_blocks [$];
    result_t want;

    int     mismatch_count;
    int     words_sent;
    int     cycle_count;
    int     hold_off;
    int     ready_gap;
    bit     steady;

    half_space_block_rasterizer_top #(
        .BLOCK_SIZE(BLOCK)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run time guard.
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Floor division for a positive divisor.
    function automatic int floor_div(int a, int b);
        int q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
            q = q - 1;
        return q;
    endfunction

    // True when the pixel lies strictly inside every edge of the triangle.
    function automatic bit pixel_inside(int px, int py);
        longint e;
        bit     ok;
        int     k;
        ok = 1'b1;
        for (k = 0; k < 3; k++) begin
            e = tri_const[k] + longint'(tri_dx[k]) * (longint'(py) * 16)
                             - longint'(tri_dy[k]) * (longint'(px) * 16);
            if (e <= 0)
                ok = 1'b0;
        end
        return ok;
    endfunction

    // Applies one command to the predicted state and returns the word it causes.
    function automatic result_t compute_block_result(logic cmd, logic [S_TDATA_W-1:0] verts);
        result_t r;
        int      vx [3];
        int      vy [3];
        int      lo_x, lo_y, hi_x, hi_y, row_lo, col, row, k, n, i, j;
        bit      full;
        r = '0;
        if (cmd == CMD_LOAD) begin
            for (k = 0; k < 3; k++) begin
                vx[k] = $signed(verts[32*k +: COORD_W]);
                vy[k] = $signed(verts[32*k+16 +: COORD_W]);
            end
            // Edge deltas and constants, with the top-left fill rule.
            for (k = 0; k < 3; k++) begin
                n = (k + 1) % 3;
                tri_dx[k] = vx[k] - vx[n];
                tri_dy[k] = vy[k] - vy[n];
                tri_const[k] = longint'(tri_dy[k]) * vx[k] - longint'(tri_dx[k]) * vy[k];
                if (tri_dy[k] < 0 || (tri_dy[k] == 0 && tri_dx[k] > 0))
                    tri_const[k] = tri_const[k] + 1;
            end
            lo_x = vx[0]; hi_x = vx[0]; lo_y = vy[0]; hi_y = vy[0];
            for (k = 1; k < 3; k++) begin
                if (vx[k] < lo_x) lo_x = vx[k];
                if (vx[k] > hi_x) hi_x = vx[k];
                if (vy[k] < lo_y) lo_y = vy[k];
                if (vy[k] > hi_y) hi_y = vy[k];
            end
            // Lower corner snapped to the block grid, upper bound exclusive.
            box_col_lo = floor_div(floor_div(lo_x + 15, 16), BLOCK) * BLOCK;
            row_lo     = floor_div(floor_div(lo_y + 15, 16), BLOCK) * BLOCK;
            box_col_hi = floor_div(hi_x + 15, 16);
            box_row_hi = floor_div(hi_y + 15, 16);
            walk_col   = box_col_lo;
            walk_row   = row_lo;
            tri_active = (box_col_lo < box_col_hi) && (row_lo < box_row_hi);
            r.last_block = !tri_active;
        end else if (!tri_active) begin
            r.last_block = 1'b1;
        end else begin
            col = walk_col;
            row = walk_row;
            for (i = 0; i < BLOCK; i++)
                for (j = 0; j < BLOCK; j++)
                    if (i * BLOCK + j < MASK_W)
                        r.coverage[i*BLOCK+j] = pixel_inside(col + j, row + i);
            full = pixel_inside(col, row) && pixel_inside(col + BLOCK - 1, row) &&
                   pixel_inside(col, row + BLOCK - 1) &&
                   pixel_inside(col + BLOCK - 1, row + BLOCK - 1);
            // Advance in row order.
            walk_col = walk_col + BLOCK;
            if (walk_col >= box_col_hi) begin
                walk_col = box_col_lo;
                walk_row = walk_row + BLOCK;
                if (walk_row >= box_row_hi)
                    tri_active = 1'b0;
            end
            r.block_valid = 1'b1;
            r.block_col   = col[POS_W-1:0];
            r.block_row   = row[POS_W-1:0];
            r.full_block  = full;
            r.last_block  = !tri_active;
        end
        return r;
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_vertices(
        logic [15:0] x0, logic [15:0] y0, logic [15:0] x1,
        logic [15:0] y1, logic [15:0] x2, logic [15:0] y2);
        return {y2, x2, y1, x1, y0, x0};
    endfunction

    // A random triangle inside a square of the given span, in 12.4 units.
    function automatic logic [S_TDATA_W-1:0] random_triangle(int span);
        logic [S_TDATA_W-1:0] v;
        int base_x, base_y, k;
        base_x = int'($urandom_range(0, 65535 - span)) - 32768;
        base_y = int'($urandom_range(0, 65535 - span)) - 32768;
        for (k = 0; k < 3; k++) begin
            v[32*k +: 16]    = 16'(base_x + int'($urandom_range(0, span)));
            v[32*k+16 +: 16] = 16'(base_y + int'($urandom_range(0, span)));
        end
        // Pixel-aligned vertices put edges exactly on sample points.
        if ($urandom_range(0, 3) == 0)
            for (k = 0; k < 6; k++)
                v[16*k +: 4] = 4'h0;
        // A shared y gives a horizontal edge.
        if ($urandom_range(0, 4) == 0)
            v[48 +: 16] = v[16 +: 16];
        return v;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, exp);
    endtask

    // Sends one word and records the result it should cause.
    task automatic send_word(logic cmd, logic [S_TDATA_W-1:0] verts);
        int gap;
        if (!steady && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 3);
            repeat (gap) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
            end
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = verts;
        do @(posedge aclk); while (!s_tready);
        pending_blocks.push_back(compute_block_result(cmd, verts));
        words_sent++;
    endtask

    task automatic send_step();
        send_word(CMD_STEP, {$urandom, $urandom, $urandom});
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_blocks.size() != 0)
            @(posedge aclk);
    endtask

    // Receiver: random short stalls, plus a long hold when one is requested.
    initial begin
        m_tready  = 1'b0;
        ready_gap = 0;
        forever begin
            @(negedge aclk);
            if (hold_off > 0) begin
                m_tready = 1'b0;
                hold_off--;
            end else if (ready_gap > 0) begin
                m_tready = 1'b0;
                ready_gap--;
            end else begin
                m_tready = 1'b1;
                if (!steady && $urandom_range(0, 5) == 0)
                    ready_gap = $urandom_range(1, 3);
            end
        end
    end

    // Compare every accepted result word with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_blocks.size() == 0) begin
                report_mismatch("word with nothing expected", m_tdata[63:0], 64'h0);
            end else begin
                want = pending_blocks.pop_front();
                if (m_tuser !== want.block_valid)
                    report_mismatch("block_valid", 64'(m_tuser), 64'(want.block_valid));
                if (m_tdata[0 +: POS_W] !== want.block_col)
                    report_mismatch("block_col", 64'(m_tdata[0 +: POS_W]),
                                    64'(want.block_col));
                if (m_tdata[POS_W +: POS_W] !== want.block_row)
                    report_mismatch("block_row", 64'(m_tdata[POS_W +: POS_W]),
                                    64'(want.block_row));
                if (m_tdata[2*POS_W +: MASK_W] !== want.coverage)
                    report_mismatch("coverage", m_tdata[2*POS_W +: MASK_W], want.coverage);
                if (m_tdata[2*POS_W+MASK_W] !== want.full_block)
                    report_mismatch("full_block", 64'(m_tdata[2*POS_W+MASK_W]),
                                    64'(want.full_block));
                if (m_tlast !== want.last_block)
                    report_mismatch("last_block", 64'(m_tlast), 64'(want.last_block));
            end
        end
    end

    // Steps with no triangle loaded report nothing left.
    task automatic test_steps_before_load();
        send_step();
        send_step();
    endtask

    // Coordinate extremes, including boxes that come out empty.
    task automatic test_coordinate_extremes();
        send_word(CMD_LOAD, pack_vertices(16'h8000, 16'h8000, 16'h7FFF, 16'h8000,
                                          16'h8000, 16'h7FFF));
        send_step();
        send_step();
        send_word(CMD_LOAD, '0);
        send_step();
        send_word(CMD_LOAD, {6{16'h7FFF}});
        send_word(CMD_LOAD, {6{16'h8000}});
        send_step();
    endtask

    // Edges through sample points: horizontal and vertical edges in both windings,
    // and a step after the last block.
    task automatic test_fill_rule();
        send_word(CMD_LOAD, pack_vertices(16'd0, 16'd0, 16'd0, 16'd128, 16'd128, 16'd0));
        send_step();
        send_word(CMD_LOAD, pack_vertices(16'd0, 16'd0, 16'd128, 16'd0, 16'd0, 16'd128));
        send_step();
        send_step();
    endtask

    // A 24 pixel triangle walked to its end: full, partial and rejected blocks.
    task automatic test_full_blocks();
        send_word(CMD_LOAD, pack_vertices(16'd0, 16'd0, 16'd0, 16'd384, 16'd384, 16'd0));
        while (tri_active)
            send_step();
    endtask

    // The receiver holds off while commands keep coming, then everything drains.
    task automatic test_backpressure();
        hold_off = 40;
        send_word(CMD_LOAD, random_triangle(600));
        repeat (12)
            send_step();
        wait_drained();
    endtask

    // Mostly whole triangles with random content, plus noise and cut-off walks.
    task automatic test_random_triangles(int count);
        int  stop_at, choice, extra;
        bit  drained;
        stop_at = words_sent + count;
        drained = 1'b0;
        while (words_sent < stop_at) begin
            if (words_sent > stop_at - 150)
                steady = 1'b1;
            if (!drained && words_sent > stop_at - count / 2) begin
                wait_drained();
                drained = 1'b1;
            end
            choice = $urandom_range(0, 9);
            if (choice < 7) begin
                send_word(CMD_LOAD,
                          random_triangle($urandom_range(0, 5) == 0 ?
                                          $urandom_range(0, 1000) : $urandom_range(0, 400)));
                while (tri_active && $urandom_range(0, 19) != 0)
                    send_step();
                extra = $urandom_range(0, 2);
                repeat (extra)
                    send_step();
            end else if (choice == 7) begin
                send_step();
            end else begin
                send_word(CMD_LOAD, {$urandom, $urandom, $urandom});
                extra = $urandom_range(1, 4);
                repeat (extra)
                    send_step();
            end
        end
    endtask

    // Test sequence.
    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tuser        = CMD_LOAD;
        s_tdata        = '0;
        hold_off       = 0;
        steady         = 1'b0;
        mismatch_count = 0;
        words_sent     = 0;
        tri_active     = 1'b0;
        for (int k = 0; k < 3; k++) begin
            tri_const[k] = 0;
            tri_dx[k]    = 0;
            tri_dy[k]    = 0;
        end
        box_col_lo = 0;
        box_col_hi = 0;
        box_row_hi = 0;
        walk_col   = 0;
        walk_row   = 0;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;

        test_steps_before_load();
        test_coordinate_extremes();
        test_fill_rule();
        test_full_blocks();
        test_backpressure();
        test_random_triangles(1100);

        wait_drained();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ half_space_block_rasterizer_top.f @@
+incdir+hdl
hdl/hsbr_pkg.sv
hdl/hsbr_in_stage.sv
hdl/hsbr_coverage.sv
hdl/hsbr_core.sv
hdl/half_space_block_rasterizer_top.sv
test/half_space_block_rasterizer_top_tb.sv
